@@ sv/lavm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_pkg
// Widths, latencies, rounding and saturation helpers shared by the look-at matrix pipeline.
// ----------------------------------------------------------------------------
package lavm_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int FW         = FRAC_BITS + 2;        // unit vector component
   localparam int UW         = FW + 1;               // true up component
   localparam int PFW        = FW + 32;              // f * up product
   localparam int CW         = PFW + 1;              // f x up component
   localparam int SHW        = $clog2(CW);
   localparam int MW         = 31;                   // normalized magnitude
   localparam int SQRT_STEPS = 32;
   localparam int LW         = 32;                   // vector length
   localparam int QW         = FRAC_BITS + 1;        // quotient bits
   localparam int NW         = LW + FRAC_BITS;       // dividend bits
   localparam int NORM_LAT   = 7 + SQRT_STEPS + QW;
   localparam int XW         = 2 * FW;               // s * f product
   localparam int PW         = FW + 34;              // s.eye, f.eye sums
   localparam int UPW        = UW + 34;              // u.eye sum
   localparam int SQSW       = 2 * FRAC_BITS + 2;
   localparam logic signed [31:0] ONE = 32'(1) << FRAC_BITS;

   // divide by 2^FRAC_BITS, round to nearest, ties away from zero
   function automatic logic signed [63:0] rescale(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? (~v + 64'(1)) : v;
      m = (m + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return v[63] ? signed'(~m + 64'(1)) : signed'(m);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         return -32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

@@ sv/lavm_norm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_norm
// Pipelined vector normalizer: magnitude scaling, bit-per-stage square root,
// three bit-per-stage dividers, sign restore.
// ----------------------------------------------------------------------------
module lavm_norm (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [lavm_pkg::CW-1:0]     vec_in  [3],
   output logic signed [lavm_pkg::FW-1:0]     nrm_out [3]
);

   localparam int CW  = lavm_pkg::CW;
   localparam int MW  = lavm_pkg::MW;
   localparam int SHW = lavm_pkg::SHW;
   localparam int NS  = lavm_pkg::SQRT_STEPS;
   localparam int QW  = lavm_pkg::QW;
   localparam int NW  = lavm_pkg::NW;
   localparam int LW  = lavm_pkg::LW;
   localparam int FW  = lavm_pkg::FW;

   // stage 1: magnitudes and max
   logic [CW-1:0]    mag_in [3];
   logic [CW-1:0]    mx_in;
   logic [CW-1:0]    mag1_ff [3];
   logic [CW-1:0]    mx1_ff;
   logic [2:0]       neg1_ff;

   // stage 2: leading one
   logic [SHW-1:0]   pos_in;
   logic [SHW-1:0]   pos2_ff;
   logic [CW-1:0]    mag2_ff [3];
   logic [2:0]       neg2_ff;
   logic             zero2_ff;

   // stage 3: shift, stage 4: squares
   logic [MW-1:0]    m_in [3];
   logic [MW-1:0]    m3_ff [3];
   logic [MW-1:0]    m4_ff [3];
   logic [2:0]       neg3_ff, neg4_ff;
   logic             zero3_ff, zero4_ff;
   logic [2*MW-1:0]  sq4_ff [3];

   // square root stages, index 0 holds the sum of squares
   logic [63:0]      x_ff [NS+1];
   logic [63:0]      r_ff [NS+1];
   logic [MW-1:0]    ms_ff [NS+1][3];
   logic [2:0]       negs_ff [NS+1];
   logic             zeros_ff [NS+1];
   logic [63:0]      x_in [NS+1];
   logic [63:0]      r_in [NS+1];

   // divider stages, index 0 holds the prepared dividend
   logic [NW-1:0]    rem_ff [QW+1][3];
   logic [QW-1:0]    q_ff [QW+1][3];
   logic [LW-1:0]    den_ff [QW+1];
   logic [2:0]       negd_ff [QW+1];
   logic             zerod_ff [QW+1];
   logic [NW-1:0]    rem_in [QW+1][3];
   logic [QW-1:0]    q_in [QW+1][3];

   logic signed [FW-1:0] out_ff [3];

   always_comb begin
      mx_in = '0;
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = vec_in[i][CW-1] ? (~vec_in[i] + CW'(1)) : vec_in[i];
         if (mag_in[i] > mx_in) begin
            mx_in = mag_in[i];
         end
      end
      pos_in = '0;
      for (int i = 0; i < CW; i++) begin
         if (mx1_ff[i]) begin
            pos_in = SHW'(i);
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (pos2_ff >= SHW'(MW - 1)) begin
            m_in[i] = MW'(mag2_ff[i] >> (pos2_ff - SHW'(MW - 1)));
         end else begin
            m_in[i] = MW'(mag2_ff[i] << (SHW'(MW - 1) - pos2_ff));
         end
      end
      x_in[0] = '0;
      r_in[0] = '0;
      for (int k = 1; k <= NS; k++) begin
         if (x_ff[k-1] >= r_ff[k-1] + (64'(1) << (2 * (NS - k)))) begin
            x_in[k] = x_ff[k-1] - (r_ff[k-1] + (64'(1) << (2 * (NS - k))));
            r_in[k] = (r_ff[k-1] >> 1) + (64'(1) << (2 * (NS - k)));
         end else begin
            x_in[k] = x_ff[k-1];
            r_in[k] = r_ff[k-1] >> 1;
         end
      end
      for (int i = 0; i < 3; i++) begin
         rem_in[0][i] = '0;
         q_in[0][i]   = '0;
         for (int j = 1; j <= QW; j++) begin
            if (rem_ff[j-1][i] >= (NW'(den_ff[j-1]) << (QW - j))) begin
               rem_in[j][i] = rem_ff[j-1][i] - (NW'(den_ff[j-1]) << (QW - j));
               q_in[j][i]   = q_ff[j-1][i] | (QW'(1) << (QW - j));
            end else begin
               rem_in[j][i] = rem_ff[j-1][i];
               q_in[j][i]   = q_ff[j-1][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag1_ff[i] <= mag_in[i];
            neg1_ff[i] <= vec_in[i][CW-1];
            mag2_ff[i] <= mag1_ff[i];
            m3_ff[i]   <= m_in[i];
            m4_ff[i]   <= m3_ff[i];
            sq4_ff[i]  <= (2*MW)'(m3_ff[i]) * (2*MW)'(m3_ff[i]);
            ms_ff[0][i] <= m4_ff[i];
         end
         mx1_ff   <= mx_in;
         pos2_ff  <= pos_in;
         neg2_ff  <= neg1_ff;
         zero2_ff <= (mx1_ff == '0);
         neg3_ff  <= neg2_ff;
         zero3_ff <= zero2_ff;
         neg4_ff  <= neg3_ff;
         zero4_ff <= zero3_ff;

         x_ff[0]     <= 64'(sq4_ff[0]) + 64'(sq4_ff[1]) + 64'(sq4_ff[2]);
         r_ff[0]     <= '0;
         negs_ff[0]  <= neg4_ff;
         zeros_ff[0] <= zero4_ff;
         for (int k = 1; k <= NS; k++) begin
            x_ff[k]     <= x_in[k];
            r_ff[k]     <= r_in[k];
            ms_ff[k]    <= ms_ff[k-1];
            negs_ff[k]  <= negs_ff[k-1];
            zeros_ff[k] <= zeros_ff[k-1];
         end

         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= (NW'(ms_ff[NS][i]) << lavm_pkg::FRAC_BITS)
                          + NW'(r_ff[NS][LW-1:1]);
            q_ff[0][i]   <= '0;
         end
         den_ff[0]   <= r_ff[NS][LW-1:0];
         negd_ff[0]  <= negs_ff[NS];
         zerod_ff[0] <= zeros_ff[NS];
         for (int j = 1; j <= QW; j++) begin
            rem_ff[j]   <= rem_in[j];
            q_ff[j]     <= q_in[j];
            den_ff[j]   <= den_ff[j-1];
            negd_ff[j]  <= negd_ff[j-1];
            zerod_ff[j] <= zerod_ff[j-1];
         end

         for (int i = 0; i < 3; i++) begin
            if (zerod_ff[QW]) begin
               out_ff[i] <= '0;
            end else if (negd_ff[QW][i]) begin
               out_ff[i] <= -signed'(FW'(q_ff[QW][i]));
            end else begin
               out_ff[i] <= signed'(FW'(q_ff[QW][i]));
            end
         end
      end
   end

   assign nrm_out = out_ff;

endmodule

@@ sv/look_at_view_matrix_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_top
// Builds the column-major look-at view matrix from eye, target and up.
// ----------------------------------------------------------------------------
// channel   dir  handshake         payload
// req       in   req_valid/stall   eye, target, upvec (x, y, z)
// rsp       out  rsp_valid/stall   column_index, row0..row3_entry, last_column
//
// One input word yields four rsp words, one per cycle while rsp is not stalled;
// once the pipeline is full, a new word is taken only as the column serializer
// releases its last column. The path from req to the first rsp word runs through
// two normalizers, each a 32-stage square root and a 17-stage divider.
// Reset clears only the valid bits and the serializer's valid bit and column count.
// A stalled output holds the pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module look_at_view_matrix_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_eye_x,
   input  logic signed [31:0] req_eye_y,
   input  logic signed [31:0] req_eye_z,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_upvec_x,
   input  logic signed [31:0] req_upvec_y,
   input  logic signed [31:0] req_upvec_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_column_index,
   output logic signed [31:0] rsp_row0_entry,
   output logic signed [31:0] rsp_row1_entry,
   output logic signed [31:0] rsp_row2_entry,
   output logic signed [31:0] rsp_row3_entry,
   output logic               rsp_last_column
);

   localparam int F   = lavm_pkg::FRAC_BITS;
   localparam int FW  = lavm_pkg::FW;
   localparam int UW  = lavm_pkg::UW;
   localparam int PFW = lavm_pkg::PFW;
   localparam int CW  = lavm_pkg::CW;
   localparam int XW  = lavm_pkg::XW;
   localparam int PW  = lavm_pkg::PW;
   localparam int UPW = lavm_pkg::UPW;
   localparam int NL  = lavm_pkg::NORM_LAT;
   localparam int SQSW = lavm_pkg::SQSW;

   logic adv;
   logic ser_free;

   // s1
   logic               v1_ff;
   logic signed [31:0] eye1_ff [3];
   logic signed [31:0] up1_ff [3];
   logic signed [32:0] d1_ff [3];
   logic signed [CW-1:0] n1_vec [3];
   logic signed [FW-1:0] f_n [3];

   // delay across first normalizer
   logic               va_ff [NL];
   logic signed [31:0] eyea_ff [NL][3];
   logic signed [31:0] upa_ff [NL][3];

   // s2, s3
   logic                  v2_ff, v3_ff;
   logic signed [PFW-1:0] pf2_ff [6];
   logic signed [31:0]    eye2_ff [3], eye3_ff [3];
   logic signed [FW-1:0]  f2_ff [3], f3_ff [3];
   logic signed [CW-1:0]  c3_ff [3];
   logic signed [FW-1:0]  n2_out [3];

   // p4, p5: short side test
   logic [CW-1:0]         cm [3];
   logic                  v4_ff, v5_ff;
   logic signed [31:0]    eye4_ff [3], eye5_ff [3];
   logic signed [FW-1:0]  f4_ff [3], f5_ff [3];
   logic signed [FW-1:0]  ss4_ff [3], ss5_ff [3];
   logic                  alls4_ff, small5_ff;
   logic [SQSW-1:0]       sqs4_ff;

   // delay across second normalizer
   logic                  vb_ff [NL-2];
   logic signed [31:0]    eyeb_ff [NL-2][3];
   logic signed [FW-1:0]  fb_ff [NL-2][3];
   logic signed [FW-1:0]  ssb_ff [NL-2][3];
   logic                  smallb_ff [NL-2];

   // s6 .. s12
   logic                  v6_ff, v7_ff, v8_ff, v9_ff, v10_ff, v11_ff, v12_ff;
   logic signed [31:0]    eye6_ff [3], eye7_ff [3], eye8_ff [3], eye9_ff [3];
   logic signed [FW-1:0]  s6_ff [3], s7_ff [3], s8_ff [3], s9_ff [3];
   logic signed [FW-1:0]  s10_ff [3], s11_ff [3], s12_ff [3];
   logic signed [FW-1:0]  f6_ff [3], f7_ff [3], f8_ff [3], f9_ff [3];
   logic signed [FW-1:0]  f10_ff [3], f11_ff [3], f12_ff [3];
   logic signed [XW-1:0]  x7_ff [6];
   logic signed [PFW-1:0] se7_ff [3], fe7_ff [3];
   logic signed [XW:0]    c8_ff [3];
   logic signed [PW-1:0]  sd8_ff, fd8_ff;
   logic signed [UW-1:0]  u9_ff [3], u10_ff [3], u11_ff [3], u12_ff [3];
   logic signed [31:0]    k0_9_ff, k2_9_ff, k0_10_ff, k2_10_ff;
   logic signed [31:0]    k0_11_ff, k2_11_ff, k0_12_ff, k2_12_ff, k1_12_ff;
   logic signed [UW+31:0] ue10_ff [3];
   logic signed [UPW-1:0] ud11_ff;

   // serializer
   logic                  ser_v_ff, ser_v_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic signed [FW-1:0]  rs_ff [3], rf_ff [3];
   logic signed [UW-1:0]  ru_ff [3];
   logic signed [31:0]    rk0_ff, rk1_ff, rk2_ff;

   assign ser_free  = !ser_v_ff || (cnt_ff == 2'd3 && !rsp_stall);
   assign adv       = !v12_ff || ser_free;
   assign req_stall = !adv;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         for (int k = 0; k < NL; k++) va_ff[k] <= 1'b0;
         v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
         for (int k = 0; k < NL - 2; k++) vb_ff[k] <= 1'b0;
         v6_ff <= 1'b0; v7_ff <= 1'b0; v8_ff <= 1'b0; v9_ff <= 1'b0;
         v10_ff <= 1'b0; v11_ff <= 1'b0; v12_ff <= 1'b0;
      end else if (adv) begin
         v1_ff    <= req_valid;
         va_ff[0] <= v1_ff;
         for (int k = 1; k < NL; k++) va_ff[k] <= va_ff[k-1];
         v2_ff    <= va_ff[NL-1];
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         vb_ff[0] <= v5_ff;
         for (int k = 1; k < NL - 2; k++) vb_ff[k] <= vb_ff[k-1];
         v6_ff  <= vb_ff[NL-3];
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
         v12_ff <= v11_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n1_vec[i] = CW'(d1_ff[i]);
         cm[i]     = c3_ff[i][CW-1] ? (~c3_ff[i] + CW'(1)) : c3_ff[i];
      end
   end

   lavm_norm u_norm_fwd (
      .clock   (clock),
      .en      (adv),
      .vec_in  (n1_vec),
      .nrm_out (f_n)
   );

   lavm_norm u_norm_side (
      .clock   (clock),
      .en      (adv),
      .vec_in  (c3_ff),
      .nrm_out (n2_out)
   );

   // datapath
   always_ff @(posedge clock) begin
      if (adv) begin
         eye1_ff[0] <= req_eye_x;   eye1_ff[1] <= req_eye_y;   eye1_ff[2] <= req_eye_z;
         up1_ff[0]  <= req_upvec_x; up1_ff[1]  <= req_upvec_y; up1_ff[2]  <= req_upvec_z;
         d1_ff[0]   <= 33'(req_target_x) - 33'(req_eye_x);
         d1_ff[1]   <= 33'(req_target_y) - 33'(req_eye_y);
         d1_ff[2]   <= 33'(req_target_z) - 33'(req_eye_z);

         eyea_ff[0] <= eye1_ff;
         upa_ff[0]  <= up1_ff;
         for (int k = 1; k < NL; k++) begin
            eyea_ff[k] <= eyea_ff[k-1];
            upa_ff[k]  <= upa_ff[k-1];
         end

         // f x up
         pf2_ff[0] <= PFW'(f_n[1]) * PFW'(upa_ff[NL-1][2]);
         pf2_ff[1] <= PFW'(f_n[2]) * PFW'(upa_ff[NL-1][1]);
         pf2_ff[2] <= PFW'(f_n[2]) * PFW'(upa_ff[NL-1][0]);
         pf2_ff[3] <= PFW'(f_n[0]) * PFW'(upa_ff[NL-1][2]);
         pf2_ff[4] <= PFW'(f_n[0]) * PFW'(upa_ff[NL-1][1]);
         pf2_ff[5] <= PFW'(f_n[1]) * PFW'(upa_ff[NL-1][0]);
         eye2_ff   <= eyea_ff[NL-1];
         f2_ff     <= f_n;

         c3_ff[0] <= CW'(pf2_ff[0]) - CW'(pf2_ff[1]);
         c3_ff[1] <= CW'(pf2_ff[2]) - CW'(pf2_ff[3]);
         c3_ff[2] <= CW'(pf2_ff[4]) - CW'(pf2_ff[5]);
         eye3_ff  <= eye2_ff;
         f3_ff    <= f2_ff;

         // short side test
         alls4_ff <= (cm[0] < (CW'(1) << F)) && (cm[1] < (CW'(1) << F))
                  && (cm[2] < (CW'(1) << F));
         sqs4_ff  <= SQSW'(cm[0][F-1:0]) * SQSW'(cm[0][F-1:0])
                   + SQSW'(cm[1][F-1:0]) * SQSW'(cm[1][F-1:0])
                   + SQSW'(cm[2][F-1:0]) * SQSW'(cm[2][F-1:0]);
         for (int i = 0; i < 3; i++) begin
            ss4_ff[i] <= FW'(lavm_pkg::rescale(64'(c3_ff[i])));
         end
         eye4_ff   <= eye3_ff;
         f4_ff     <= f3_ff;

         small5_ff <= alls4_ff && (sqs4_ff[SQSW-1:2*F] == '0);
         ss5_ff    <= ss4_ff;
         eye5_ff   <= eye4_ff;
         f5_ff     <= f4_ff;

         eyeb_ff[0]   <= eye5_ff;
         fb_ff[0]     <= f5_ff;
         ssb_ff[0]    <= ss5_ff;
         smallb_ff[0] <= small5_ff;
         for (int k = 1; k < NL - 2; k++) begin
            eyeb_ff[k]   <= eyeb_ff[k-1];
            fb_ff[k]     <= fb_ff[k-1];
            ssb_ff[k]    <= ssb_ff[k-1];
            smallb_ff[k] <= smallb_ff[k-1];
         end

         s6_ff   <= smallb_ff[NL-3] ? ssb_ff[NL-3] : n2_out;
         eye6_ff <= eyeb_ff[NL-3];
         f6_ff   <= fb_ff[NL-3];

         // s x f and dot products
         x7_ff[0] <= XW'(s6_ff[1]) * XW'(f6_ff[2]);
         x7_ff[1] <= XW'(s6_ff[2]) * XW'(f6_ff[1]);
         x7_ff[2] <= XW'(s6_ff[2]) * XW'(f6_ff[0]);
         x7_ff[3] <= XW'(s6_ff[0]) * XW'(f6_ff[2]);
         x7_ff[4] <= XW'(s6_ff[0]) * XW'(f6_ff[1]);
         x7_ff[5] <= XW'(s6_ff[1]) * XW'(f6_ff[0]);
         for (int i = 0; i < 3; i++) begin
            se7_ff[i] <= PFW'(s6_ff[i]) * PFW'(eye6_ff[i]);
            fe7_ff[i] <= PFW'(f6_ff[i]) * PFW'(eye6_ff[i]);
         end
         eye7_ff <= eye6_ff;
         s7_ff   <= s6_ff;
         f7_ff   <= f6_ff;

         c8_ff[0] <= (XW+1)'(x7_ff[0]) - (XW+1)'(x7_ff[1]);
         c8_ff[1] <= (XW+1)'(x7_ff[2]) - (XW+1)'(x7_ff[3]);
         c8_ff[2] <= (XW+1)'(x7_ff[4]) - (XW+1)'(x7_ff[5]);
         sd8_ff   <= PW'(se7_ff[0]) + PW'(se7_ff[1]) + PW'(se7_ff[2]);
         fd8_ff   <= PW'(fe7_ff[0]) + PW'(fe7_ff[1]) + PW'(fe7_ff[2]);
         eye8_ff  <= eye7_ff;
         s8_ff    <= s7_ff;
         f8_ff    <= f7_ff;

         for (int i = 0; i < 3; i++) begin
            u9_ff[i] <= UW'(lavm_pkg::rescale(64'(c8_ff[i])));
         end
         k0_9_ff <= lavm_pkg::sat32(-lavm_pkg::rescale(64'(sd8_ff)));
         k2_9_ff <= lavm_pkg::sat32(lavm_pkg::rescale(64'(fd8_ff)));
         eye9_ff <= eye8_ff;
         s9_ff   <= s8_ff;
         f9_ff   <= f8_ff;

         for (int i = 0; i < 3; i++) begin
            ue10_ff[i] <= (UW+32)'(u9_ff[i]) * (UW+32)'(eye9_ff[i]);
         end
         u10_ff   <= u9_ff;
         s10_ff   <= s9_ff;
         f10_ff   <= f9_ff;
         k0_10_ff <= k0_9_ff;
         k2_10_ff <= k2_9_ff;

         ud11_ff  <= UPW'(ue10_ff[0]) + UPW'(ue10_ff[1]) + UPW'(ue10_ff[2]);
         u11_ff   <= u10_ff;
         s11_ff   <= s10_ff;
         f11_ff   <= f10_ff;
         k0_11_ff <= k0_10_ff;
         k2_11_ff <= k2_10_ff;

         k1_12_ff <= lavm_pkg::sat32(-lavm_pkg::rescale(64'(ud11_ff)));
         u12_ff   <= u11_ff;
         s12_ff   <= s11_ff;
         f12_ff   <= f11_ff;
         k0_12_ff <= k0_11_ff;
         k2_12_ff <= k2_11_ff;
      end

      if (ser_free) begin
         rs_ff  <= s12_ff;
         ru_ff  <= u12_ff;
         rf_ff  <= f12_ff;
         rk0_ff <= k0_12_ff;
         rk1_ff <= k1_12_ff;
         rk2_ff <= k2_12_ff;
      end
   end

   // column serializer
   always_comb begin
      ser_v_in = ser_v_ff;
      cnt_in   = cnt_ff;
      if (ser_free) begin
         ser_v_in = v12_ff;
         cnt_in   = 2'd0;
      end else if (!rsp_stall) begin
         cnt_in = cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_v_ff <= 1'b0;
         cnt_ff   <= 2'd0;
      end else begin
         ser_v_ff <= ser_v_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      rsp_row3_entry = '0;
      unique case (cnt_ff)
         2'd0: begin
            rsp_row0_entry = 32'(rs_ff[0]);
            rsp_row1_entry = 32'(ru_ff[0]);
            rsp_row2_entry = -32'(rf_ff[0]);
         end
         2'd1: begin
            rsp_row0_entry = 32'(rs_ff[1]);
            rsp_row1_entry = 32'(ru_ff[1]);
            rsp_row2_entry = -32'(rf_ff[1]);
         end
         2'd2: begin
            rsp_row0_entry = 32'(rs_ff[2]);
            rsp_row1_entry = 32'(ru_ff[2]);
            rsp_row2_entry = -32'(rf_ff[2]);
         end
         default: begin
            rsp_row0_entry = rk0_ff;
            rsp_row1_entry = rk1_ff;
            rsp_row2_entry = rk2_ff;
            rsp_row3_entry = lavm_pkg::ONE;
         end
      endcase
   end

   assign rsp_valid        = ser_v_ff;
   assign rsp_column_index = cnt_ff;
   assign rsp_last_column  = (cnt_ff == 2'd3);

endmodule
